// ===== rtl/cjt_pkg.sv =====
// Shared types and constants of the cosine joint trajectory generator.
package cjt_pkg;

  typedef enum logic [2:0] {
    OP_START,
    OP_BADTIME,
    OP_BADMODE,
    OP_TICK,
    OP_LOAD,
    OP_NOP,
    OP_RANGE
  } op_kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_TIME = 3'd1,
    ST_BAD_MODE = 3'd2,
    ST_MOVING   = 3'd3,
    ST_DONE     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_REL = 2'd0,
    MODE_ABS = 2'd1
  } mode_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_READ,
    BS_EXEC,
    BS_DIVG,
    BS_DIVP,
    BS_ROM,
    BS_WGT,
    BS_MUL,
    BS_APPLY,
    BS_FIN
  } back_state_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [4:0]         joint;
    logic signed [31:0] angle;
    logic [15:0]        time_ms;
    logic [1:0]         mode;
  } op_t;

  typedef struct packed {
    logic signed [31:0] cur;
    logic signed [31:0] tgt;
    logic signed [31:0] start;
    logic signed [32:0] delta;
    logic [15:0]        tick;
    logic [15:0]        goal;
  } rec_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] reference;
  } res_t;

  localparam logic [7:0] TICK_PERIOD_RESET = 8'd5;

endpackage

// ===== rtl/cosine_joint_trajectory_generator_top.sv =====
// Top level of the raised-cosine joint trajectory generator.
// Commands are handled one at a time: a load, error, unused-command, idle or finishing tick passes
// through the read, execute and finish states, a start move also waits on the bit-serial
// divider, and a tick of a moving joint waits on the divider and then the lookup, weight,
// multiply and apply steps; the back end takes no new item until it has issued the last result.
// Reset (synchronous, active high) empties both queues, idles every joint, makes every joint
// read as zero and returns the tick period to 5 ms.
module cosine_joint_trajectory_generator_top import cjt_pkg::*; #(
  parameter int JOINTS     = 32,
  parameter int TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         cmd,
  input  logic [4:0]         joint,
  input  logic signed [31:0] angle,
  input  logic [15:0]        time_ms,
  input  logic [1:0]         mode,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status,
  output logic signed [31:0] reference,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  // The tick period register; a value of zero is treated as one by the back end.
  logic [7:0] tick_period;

  op_t  op_head;
  logic op_empty;
  logic op_pop;
  logic res_full;
  logic res_push;
  res_t res_data;
  res_t res_head;
  logic [$bits(res_t)-1:0] res_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_PERIOD_RESET;
    end else if (cfg_we) begin
      tick_period <= cfg_wdata;
    end
  end

  // The front end classifies each transfer and holds it in a short queue, so
  // that new commands are taken while the back end is busy.
  cjt_front #(
    .JOINTS(JOINTS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .cmd     (cmd),
    .joint   (joint),
    .angle   (angle),
    .time_ms (time_ms),
    .mode    (mode),
    .op_pop  (op_pop),
    .op_head (op_head),
    .op_empty(op_empty)
  );

  // The back end owns the per-joint state memory, the divider and the weight
  // table, and issues exactly one result for each command it takes.
  cjt_back #(
    .JOINTS    (JOINTS),
    .TABLE_BITS(TABLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .op_head    (op_head),
    .op_empty   (op_empty),
    .op_pop     (op_pop),
    .tick_period(tick_period),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  // Results wait here until the consumer pops them.
  cjt_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_data),
    .full (res_full),
    .pop  (pop),
    .dout (res_bits),
    .empty(empty)
  );

  assign res_head  = res_t'(res_bits);
  assign status    = res_head.status;
  assign reference = res_head.reference;

endmodule

// ===== rtl/cjt_ram.sv =====
// Generic single-port-write, registered-read RAM.
module cjt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cjt_fifo.sv =====
// Small register-based queue with full and empty flags.
module cjt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign dout    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/cjt_front.sv =====
// Front end: classifies incoming commands and queues them for the back end.
module cjt_front import cjt_pkg::*; #(
  parameter int JOINTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         cmd,
  input  logic [4:0]         joint,
  input  logic signed [31:0] angle,
  input  logic [15:0]        time_ms,
  input  logic [1:0]         mode,
  input  logic               op_pop,
  output op_t                op_head,
  output logic               op_empty
);

  op_t              op_in;
  op_kind_t         kind;
  logic [$bits(op_t)-1:0] head_bits;

  always_comb begin
    kind = OP_NOP;
    if (32'(joint) >= JOINTS) begin
      kind = OP_RANGE;
    end else begin
      case (cmd)
        CMD_START: begin
          if (time_ms == '0) begin
            kind = OP_BADTIME;
          end else if (mode != MODE_REL && mode != MODE_ABS) begin
            kind = OP_BADMODE;
          end else begin
            kind = OP_START;
          end
        end
        CMD_TICK: kind = OP_TICK;
        CMD_LOAD: kind = OP_LOAD;
        default:  kind = OP_NOP;
      endcase
    end
  end

  assign op_in = '{kind: kind, joint: joint, angle: angle, time_ms: time_ms, mode: mode};

  cjt_fifo #(
    .WIDTH($bits(op_t)),
    .DEPTH(2)
  ) u_op_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (op_in),
    .full (full),
    .pop  (op_pop),
    .dout (head_bits),
    .empty(op_empty)
  );

  assign op_head = op_t'(head_bits);

endmodule

// ===== rtl/cjt_div.sv =====
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
module cjt_div #(
  parameter int DW = 26
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [16:0]   rem;
  logic [15:0]   dsr;
  logic [16:0]   rem_sh;
  logic          ge;

  assign rem_sh   = {rem[15:0], dvd[DW-1]};
  assign ge       = (rem_sh >= {1'b0, dsr});
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, dsr}) : rem_sh;
      dvd <= {dvd[DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/cjt_back.sv =====
// Back end: per-joint state, move set-up, tick interpolation and result issue.
module cjt_back import cjt_pkg::*; #(
  parameter int JOINTS     = 32,
  parameter int TABLE_BITS = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  op_t        op_head,
  input  logic       op_empty,
  output logic       op_pop,
  input  logic [7:0] tick_period,
  input  logic       res_full,
  output logic       res_push,
  output res_t       res_data
);

  localparam int JW   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int TB   = TABLE_BITS;
  localparam int DW   = 16 + TB;
  localparam int HALF = 1 << (TB - 1);
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned TWO_N  = 64'd2 << TB;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [63:0] ROUND_Q30  = 64'h2000_0000;

  typedef logic [30:0] wtab_t [HALF + 1];
  typedef longint unsigned sdiv_t [5];
  localparam sdiv_t SDIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  function automatic logic [30:0] half_weight(longint unsigned p);
    longint unsigned phi;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned s;
    phi  = (p * PI_Q30) / TWO_N;
    x2   = (phi * phi) >> 30;
    term = phi;
    sum  = longint'(phi);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / SDIV[k - 1];
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    s = (sum < 0) ? 64'd0 : longint'(sum);
    return 31'((s * s) >> 30);
  endfunction

  function automatic wtab_t build_wtab();
    wtab_t t;
    for (int i = 0; i <= HALF; i++) begin
      t[i] = half_weight(longint'(i));
    end
    return t;
  endfunction

  localparam wtab_t WTAB = build_wtab();

  function automatic logic [31:0] sat32(logic signed [35:0] v);
    logic [31:0] r;
    if (!v[35] && (|v[34:31])) begin
      r = 32'h7FFF_FFFF;
    end else if (v[35] && !(&v[34:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  back_state_t state, state_next;
  op_t         op_q;
  rec_t        rec;
  rec_t        rdata;
  logic [JOINTS-1:0] valid;
  logic [JOINTS-1:0] moving;
  logic [JW-1:0]     jidx;
  status_t           status;
  logic              wr;
  logic [TB-1:0]     p;
  logic [TB-1:0]     rom_idx;
  logic [30:0]       rom_q;
  logic [30:0]       w;
  logic [62:0]       prod;
  logic              neg;
  logic              ram_we;
  logic              div_start;
  logic              div_done;
  logic [DW-1:0]     div_q;
  logic [DW-1:0]     dividend;
  logic [15:0]       divisor;
  logic [7:0]        per;
  logic [15:0]       tick_inc;
  logic              finish;
  logic signed [35:0] tgt_wide;
  logic [31:0]       tgt_sat;
  logic [32:0]       delta_abs;
  logic [63:0]       rsum;
  logic signed [35:0] v_wide;
  logic [$bits(rec_t)-1:0] ram_rd;

  assign jidx     = JW'(op_q.joint);
  assign per      = (tick_period == '0) ? 8'd1 : tick_period;
  assign tick_inc = rec.tick + 16'd1;
  assign finish   = (rec.goal <= tick_inc);
  assign tgt_wide = (op_q.mode == MODE_REL)
                  ? ({{4{rec.cur[31]}}, rec.cur} + {{4{op_q.angle[31]}}, op_q.angle})
                  : {{4{op_q.angle[31]}}, op_q.angle};
  assign tgt_sat  = sat32(tgt_wide);
  assign dividend = (op_q.kind == OP_START) ? DW'(op_q.time_ms) : {tick_inc, TB'(0)};
  assign divisor  = (op_q.kind == OP_START) ? {8'd0, per} : rec.goal;
  assign rom_idx  = (32'(p) <= HALF) ? p : TB'((1 << TB) - 32'(p));
  assign delta_abs = rec.delta[32] ? (33'd0 - rec.delta) : rec.delta;
  assign rsum     = {1'b0, prod} + ROUND_Q30;
  assign v_wide   = {{4{rec.start[31]}}, rec.start}
                  + (neg ? (36'sd0 - {2'b00, rsum[63:30]}) : {2'b00, rsum[63:30]});
  assign rdata    = rec_t'(ram_rd);

  cjt_ram #(
    .WIDTH($bits(rec_t)),
    .DEPTH(JOINTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(jidx),
    .wdata(rec),
    .raddr(JW'(op_head.joint)),
    .rdata(ram_rd)
  );

  cjt_div #(
    .DW(DW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dividend),
    .divisor (divisor),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      BS_IDLE:  if (!op_empty && !res_full) state_next = BS_READ;
      BS_READ:  state_next = BS_EXEC;
      BS_EXEC: begin
        if (op_q.kind == OP_START) begin
          state_next = BS_DIVG;
        end else if (op_q.kind == OP_TICK && moving[jidx] && !finish) begin
          state_next = BS_DIVP;
        end else begin
          state_next = BS_FIN;
        end
      end
      BS_DIVG:  if (div_done) state_next = BS_FIN;
      BS_DIVP:  if (div_done) state_next = BS_ROM;
      BS_ROM:   state_next = BS_WGT;
      BS_WGT:   state_next = BS_MUL;
      BS_MUL:   state_next = BS_APPLY;
      BS_APPLY: state_next = BS_FIN;
      BS_FIN:   state_next = BS_IDLE;
      default:  state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    op_pop    = (state == BS_IDLE) && !op_empty && !res_full;
    div_start = (state == BS_EXEC) && (state_next == BS_DIVG || state_next == BS_DIVP);
    ram_we    = (state == BS_FIN) && wr;
    res_push  = (state == BS_FIN);
    res_data.status    = status;
    res_data.reference = (op_q.kind == OP_RANGE) ? 32'sd0 : rec.cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      moving <= '0;
    end else begin
      if (ram_we) begin
        valid[jidx] <= 1'b1;
      end
      if (state == BS_EXEC) begin
        case (op_q.kind)
          OP_BADMODE, OP_LOAD, OP_START: moving[jidx] <= 1'b0;
          OP_TICK: if (finish) moving[jidx] <= 1'b0;
          default: ;
        endcase
      end else if (state == BS_DIVG && div_done) begin
        moving[jidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BS_IDLE: begin
        op_q <= op_head;
      end
      BS_READ: begin
        rec <= valid[jidx] ? rdata : '0;
      end
      BS_EXEC: begin
        wr     <= 1'b0;
        status <= ST_OK;
        case (op_q.kind)
          OP_RANGE:   status <= ST_MOVING;
          OP_BADTIME: status <= ST_BAD_TIME;
          OP_BADMODE: status <= ST_BAD_MODE;
          OP_LOAD: begin
            rec.cur <= op_q.angle;
            wr      <= 1'b1;
          end
          OP_START: begin
            rec.tgt   <= tgt_sat;
            rec.start <= rec.cur;
            rec.delta <= {tgt_sat[31], tgt_sat} - {rec.cur[31], rec.cur};
            rec.tick  <= '0;
            wr        <= 1'b1;
          end
          OP_TICK: begin
            status <= ST_MOVING;
            if (moving[jidx]) begin
              wr <= 1'b1;
              if (finish) begin
                rec.tick <= '0;
                rec.goal <= '0;
                rec.cur  <= rec.tgt;
                status   <= ST_DONE;
              end else begin
                rec.tick <= tick_inc;
              end
            end
          end
          default: ;
        endcase
      end
      BS_DIVG: begin
        if (div_done) begin
          rec.goal <= div_q[15:0];
        end
      end
      BS_DIVP: begin
        if (div_done) begin
          p <= div_q[TB-1:0];
        end
      end
      BS_ROM: begin
        rom_q <= WTAB[rom_idx];
      end
      BS_WGT: begin
        w <= (32'(p) <= HALF) ? rom_q : (ONE_Q30 - rom_q);
      end
      BS_MUL: begin
        neg  <= rec.delta[32];
        prod <= {31'd0, delta_abs[31:0]} * {32'd0, w};
      end
      BS_APPLY: begin
        rec.cur <= sat32(v_wide);
      end
      default: ;
    endcase
  end

endmodule

// ===== sim/cjt_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts each joint's reference from the command stream and compares results.
module cjt_checker import cjt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         cmd,
  input  logic [4:0]         joint,
  input  logic signed [31:0] angle,
  input  logic [15:0]        time_ms,
  input  logic [1:0]         mode,
  input  logic               empty,
  input  logic               pop,
  input  logic [2:0]         status,
  input  logic signed [31:0] reference,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  output int                 errors,
  output int                 outstanding
);

  localparam int NJ = 32;
  localparam int TB = 10;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  logic [7:0]         period;
  logic signed [31:0] cur_ref [NJ];
  logic signed [31:0] tgt_ref [NJ];
  logic signed [31:0] org_ref [NJ];
  longint             delta   [NJ];
  logic [15:0]        ticks   [NJ];
  logic [15:0]        goal    [NJ];
  logic               busy    [NJ];
  res_t               pending_results [$];

  assign outstanding = pending_results.size();

  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    return (sum < 0) ? 0 : longint'(sum);
  endfunction

  function automatic longint unsigned half_weight(longint unsigned p);
    longint unsigned s;
    s = sine_q30((p * PI_Q30) / (64'd2 << TB));
    return (s * s) >> 30;
  endfunction

  function automatic longint unsigned blend_weight(longint unsigned p);
    longint unsigned n;
    n = 64'd1 << TB;
    if (p > n) p = n;
    if (p <= n / 2) return half_weight(p);
    return ONE_Q30 - half_weight(n - p);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Applies one command to the joint state and returns the result it gives.
  function automatic res_t apply_command(logic [1:0] c, logic [4:0] j, logic signed [31:0] a,
                                         logic [15:0] t, logic [1:0] m);
    res_t r;
    longint tgt;
    longint unsigned per;
    longint unsigned p;
    longint unsigned mag;
    longint unsigned stp;
    longint v;
    r.status = ST_OK;
    case (c)
      CMD_START: begin
        if (t == 0) begin
          r.status = ST_BAD_TIME;
        end else begin
          busy[j] = 1'b0;
          if (m != MODE_REL && m != MODE_ABS) begin
            r.status = ST_BAD_MODE;
          end else begin
            tgt = (m == MODE_REL) ? longint'(cur_ref[j]) + longint'(a) : longint'(a);
            per = (period == 0) ? 1 : period;
            tgt_ref[j] = clamp32(tgt);
            org_ref[j] = cur_ref[j];
            delta[j] = longint'(clamp32(tgt)) - longint'(cur_ref[j]);
            ticks[j] = '0;
            goal[j] = 16'(longint'(t) / per);
            busy[j] = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (!busy[j]) begin
          r.status = ST_MOVING;
        end else begin
          ticks[j] = ticks[j] + 16'd1;
          if (goal[j] <= ticks[j]) begin
            ticks[j] = '0;
            goal[j] = '0;
            cur_ref[j] = tgt_ref[j];
            busy[j] = 1'b0;
            r.status = ST_DONE;
          end else begin
            p = (longint'(ticks[j]) << TB) / longint'(goal[j]);
            mag = (delta[j] < 0) ? -delta[j] : delta[j];
            stp = (mag * blend_weight(p) + (64'd1 << 29)) >> 30;
            v = longint'(org_ref[j]) + ((delta[j] < 0) ? -longint'(stp) : longint'(stp));
            cur_ref[j] = clamp32(v);
            r.status = ST_MOVING;
          end
        end
      end
      CMD_LOAD: begin
        busy[j] = 1'b0;
        cur_ref[j] = a;
      end
      default: ;
    endcase
    r.reference = cur_ref[j];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      period = TICK_PERIOD_RESET;
      for (int i = 0; i < NJ; i++) begin
        cur_ref[i] = '0;
        tgt_ref[i] = '0;
        org_ref[i] = '0;
        delta[i] = 0;
        ticks[i] = '0;
        goal[i] = '0;
        busy[i] = 1'b0;
      end
      pending_results.delete();
    end else begin
      if (cfg_we) period = cfg_wdata;
      if (push && !full)
        pending_results.push_back(apply_command(cmd, joint, angle, time_ms, mode));
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $display("%t: result transfer with nothing expected", $realtime);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) report("status", status, want.status);
          if (reference !== want.reference) report("reference", reference, want.reference);
        end
      end
    end
  end

endmodule

// ===== sim/tb_cosine_joint_trajectory_generator_top.sv =====
`timescale 1ns / 1ps
// Testbench top: drives command traffic and tick period settings, and gives the verdict.
module tb_cosine_joint_trajectory_generator_top;
  import cjt_pkg::*;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [1:0]         cmd;
  logic [4:0]         joint;
  logic signed [31:0] angle;
  logic [15:0]        time_ms;
  logic [1:0]         mode;
  logic               empty;
  logic               pop;
  logic [2:0]         status;
  logic signed [31:0] reference;
  logic               cfg_we;
  logic [7:0]         cfg_wdata;
  int                 errors;
  int                 outstanding;

  // Idle control: when a quiet flag is set that side never pauses.
  bit                 quiet_tx;
  bit                 quiet_rx;
  int                 rx_stall;
  logic [7:0]         cur_period;

  cosine_joint_trajectory_generator_top uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd), .joint(joint),
    .angle(angle), .time_ms(time_ms), .mode(mode), .empty(empty), .pop(pop),
    .status(status), .reference(reference), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  cjt_checker checker_i (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd), .joint(joint),
    .angle(angle), .time_ms(time_ms), .mode(mode), .empty(empty), .pop(pop),
    .status(status), .reference(reference), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // The result side stalls for a freshly drawn number of cycles after each
  // transfer, unless it is in a quiet stretch.
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      pop <= 1'b0;
      rx_stall <= 0;
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      pop <= (rx_stall == 1);
    end else if (pop && !empty) begin
      gap = quiet_rx ? 0 : $urandom_range(0, 17);
      rx_stall <= gap;
      pop <= (gap == 0);
    end else begin
      pop <= 1'b1;
    end
  end

  // Sends one command, after a random pause, and waits for its transfer. The
  // push line is only lowered when a pause follows, so it never toggles twice
  // in one step.
  task automatic send(cmd_t c, int j, logic [31:0] a, int t, int m);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    joint <= j[4:0];
    angle <= a;
    time_ms <= t[15:0];
    mode <= m[1:0];
    do @(posedge clk); while (full);
  endtask

  // The tick period is only changed once every result has come back and the
  // block has had time to finish any work left inside it.
  task automatic drain_and_set(logic [7:0] p);
    push <= 1'b0;
    wait (outstanding == 0);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    cur_period = p;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly ticks and well-formed moves on a handful of joints, so that ticks find
  // moving joints and moves run to completion; the rest is loads, errors,
  // the unused command and noise across every joint.
  task automatic random_traffic(int count);
    int sel;
    int j;
    int per;
    int t;
    per = (cur_period == 0) ? 1 : cur_period;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        quiet_tx = ($urandom_range(0, 3) == 0);
        quiet_rx = ($urandom_range(0, 3) == 0);
      end
      sel = $urandom_range(0, 99);
      j = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
      if (sel < 14) begin
        t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                         : $urandom_range(1, per * 24 + 1);
        if (t > 65535) t = 65535;
        send(CMD_START, j, $urandom, t, $urandom_range(0, 5) == 0 ? $urandom_range(0, 3)
                                                                 : $urandom_range(0, 1));
      end else if (sel < 84) begin
        send(CMD_TICK, j, $urandom, $urandom_range(0, 65535), $urandom_range(0, 3));
      end else if (sel < 92) begin
        send(CMD_LOAD, j, $urandom, $urandom_range(0, 65535), $urandom_range(0, 3));
      end else if (sel < 96) begin
        send(CMD_START, j, $urandom, 0, $urandom_range(0, 3));
      end else begin
        send(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom,
             $urandom_range(0, 65535), $urandom_range(0, 3));
      end
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    cmd = CMD_START;
    joint = '0;
    angle = '0;
    time_ms = '0;
    mode = MODE_REL;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
    cur_period = TICK_PERIOD_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset tick period of 5 ms.
    send(CMD_TICK, 0, 32'h0, 0, 0);                 // tick on an idle joint
    send(CMD_LOAD, 0, 32'h7fffffff, 0, 0);          // largest reference
    send(CMD_START, 0, 32'h7fffffff, 10, 0);        // relative target saturates high
    send(CMD_TICK, 0, 32'h0, 0, 0);
    send(CMD_TICK, 0, 32'h0, 0, 0);                 // reaches the goal
    send(CMD_LOAD, 31, 32'h80000000, 65535, 3);     // smallest reference
    send(CMD_START, 31, 32'h80000000, 65535, 0);    // relative target saturates low
    send(CMD_START, 31, 32'h7fffffff, 65535, 1);    // absolute move, longest time
    send(CMD_TICK, 31, 32'h0, 0, 0);
    send(CMD_TICK, 31, 32'h0, 0, 0);
    send(CMD_LOAD, 31, 32'h00010000, 0, 0);         // load stops the move
    send(CMD_TICK, 31, 32'h0, 0, 0);
    send(CMD_START, 2, 32'h00100000, 0, 1);         // zero goal time
    send(CMD_START, 2, 32'h00100000, 20, 2);        // unsupported modes
    send(CMD_START, 2, 32'h00100000, 20, 3);
    send(CMD_TICK, 2, 32'h0, 0, 0);
    send(CMD_START, 3, 32'hfff00000, 3, 1);         // goal of zero ticks
    send(CMD_TICK, 3, 32'h0, 0, 0);
    send(CMD_NONE, 3, 32'hffffffff, 65535, 3);      // unused command
    send(CMD_START, 4, 32'h12345678, 25, 0);
    send(CMD_TICK, 4, 32'h0, 0, 0);
    send(CMD_TICK, 4, 32'h0, 0, 0);
    send(CMD_START, 4, 32'h00000001, 100, 1);       // restart while moving
    send(CMD_TICK, 4, 32'h0, 0, 0);

    random_traffic(250);
    drain_and_set(8'd1);
    random_traffic(250);
    drain_and_set(8'd255);
    random_traffic(200);
    drain_and_set(8'd0);      // a zero period behaves as one millisecond
    random_traffic(200);
    drain_and_set(8'($urandom_range(1, 255)));
    random_traffic(200);
    drain_and_set(8'($urandom_range(2, 12)));
    random_traffic(250);
    drain_and_set(8'd5);
    random_traffic(150);

    push <= 1'b0;
    wait (outstanding == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
